// ===== rtl/core/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; every other file of the decoder imports this package.
package u8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned REM_W  = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CONT = 2'd1,
    ST_BAD_LEAD = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_buffer;
  } byte_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    status_t          status;
  } result_t;

endpackage

// ===== rtl/core/u8d_byte_if.sv =====
// Valid/ready channel carrying one raw byte and its end-of-buffer flag.
// Depends on u8d_pkg for field widths.
interface u8d_byte_if;
  import u8d_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_buffer;

  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

// ===== rtl/core/u8d_cp_if.sv =====
// Valid/ready channel carrying one decoded code point, its length and status.
// Depends on u8d_pkg for field widths.
interface u8d_cp_if;
  import u8d_pkg::*;

  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] seq_length;
  logic [1:0]       status;

  modport source (output valid, output code_point, output seq_length, output status,
                  input ready);
  modport sink   (input valid, input code_point, input seq_length, input status,
                  output ready);
endinterface

// ===== rtl/core/utf8_stream_decoder.sv =====
// UTF-8 stream decoder, top level.
// Depends on u8d_pkg, u8d_byte_if, u8d_cp_if, u8d_in_stage, u8d_step, u8d_out_stage.
//
// The decoder takes one byte per input transaction and returns at most one
// result transaction per byte: a code point with its sequence length and a
// status (ok, bad continuation, bad lead byte, truncated). A byte is first
// captured in the input register; when the result register has room, the step
// logic takes it and any result it closes is loaded into the result register,
// which drives out_chan.valid. A new byte is taken every cycle while the
// result side keeps up; the rate is set by the update of the sequence state
// (accumulator, remaining count, length, error flag), which must finish before
// the next byte is examined. A byte waits in the input register while the
// result register holds an unread result, even if that byte would produce no
// result itself. Bytes that open or continue a sequence produce no result until
// the sequence ends. Overlong forms, surrogates and values above U+10FFFF are
// passed through as ok.
module utf8_stream_decoder (
  input  logic      clk,
  input  logic      rst_n,
  u8d_byte_if.sink  in_chan,
  u8d_cp_if.source  out_chan
);
  import u8d_pkg::*;

  logic       item_valid;
  byte_item_t item;
  logic       consume;
  logic       res_space;
  logic       res_valid;
  result_t    res;
  logic       res_load;

  // Input register; it refills in the same cycle the step logic takes its byte.
  u8d_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  // Sequence state and result formation. A byte is only taken when the result
  // register has room, so a result is never dropped.
  u8d_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .res_space  (res_space),
    .consume    (consume),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign res_load = consume && res_valid;

  // Result register toward the consumer.
  u8d_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .res_space (res_space),
    .out_chan  (out_chan)
  );
endmodule

// ===== rtl/core/u8d_in_stage.sv =====
// Input register of the UTF-8 decoder: captures one byte transaction.
// Depends on u8d_pkg and u8d_byte_if.
module u8d_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  u8d_byte_if.sink            in_chan,
  input  logic                consume,
  output logic                item_valid,
  output u8d_pkg::byte_item_t item
);
  import u8d_pkg::*;

  logic       vld_r;
  logic       vld_nxt;
  byte_item_t item_r;
  logic       load;

  // The register frees up in the same cycle its content is consumed.
  assign in_chan.ready = !vld_r || consume;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (consume) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.in_byte       <= in_chan.in_byte;
      item_r.end_of_buffer <= in_chan.end_of_buffer;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;
endmodule

// ===== rtl/core/u8d_step.sv =====
// Sequence tracking for the UTF-8 decoder: classifies each byte, keeps the
// accumulator and counters, and forms the result. Depends on u8d_pkg.
module u8d_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  u8d_pkg::byte_item_t item,
  input  logic                res_space,
  output logic                consume,
  output logic                res_valid,
  output u8d_pkg::result_t    res
);
  import u8d_pkg::*;

  logic [CP_W-1:0]  acc_r,  acc_nxt;
  logic [REM_W-1:0] rem_r,  rem_nxt;
  logic [LEN_W-1:0] len_r,  len_nxt;
  logic             cerr_r, cerr_nxt;

  logic [BYTE_W-1:0] b;
  logic              last;
  logic [LEN_W-1:0]  lead_len;
  logic [CP_W-1:0]   lead_payload;
  logic              lead_ascii;
  logic              lead_bad;
  logic [CP_W-1:0]   acc_upd;
  logic              cerr_upd;
  logic [REM_W-1:0]  rem_dec;

  assign b       = item.in_byte;
  assign last    = item.end_of_buffer;
  assign consume = item_valid && res_space;

  // Lead byte classification by its high bits.
  always_comb begin
    lead_ascii   = 1'b0;
    lead_bad     = 1'b0;
    lead_len     = '0;
    lead_payload = '0;
    if (!b[7]) begin
      lead_ascii   = 1'b1;
      lead_len     = LEN_W'(1);
      lead_payload = CP_W'(b[6:0]);
    end else if (b[7:5] == 3'b110) begin
      lead_len     = LEN_W'(2);
      lead_payload = CP_W'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      lead_len     = LEN_W'(3);
      lead_payload = CP_W'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      lead_len     = LEN_W'(4);
      lead_payload = CP_W'(b[2:0]);
    end else begin
      lead_bad = 1'b1;
    end
  end

  // Continuation byte: once an error is seen, later bytes are only counted.
  always_comb begin
    acc_upd  = acc_r;
    cerr_upd = cerr_r;
    if (!cerr_r) begin
      if (b[7:6] != 2'b10) begin
        cerr_upd = 1'b1;
      end else begin
        acc_upd = {acc_r[CP_W-7:0], b[5:0]};
      end
    end
    rem_dec = rem_r - REM_W'(1);
  end

  always_comb begin
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    len_nxt   = len_r;
    cerr_nxt  = cerr_r;
    res_valid = 1'b0;
    res       = '{code_point: '0, seq_length: '0, status: ST_OK};
    if (rem_r == '0) begin
      if (lead_ascii) begin
        res_valid = 1'b1;
        res       = '{code_point: lead_payload, seq_length: lead_len, status: ST_OK};
      end else if (lead_bad) begin
        res_valid = 1'b1;
        res       = '{code_point: '0, seq_length: '0, status: ST_BAD_LEAD};
      end else if (last) begin
        res_valid = 1'b1;
        res       = '{code_point: '0, seq_length: lead_len, status: ST_TRUNC};
      end else begin
        acc_nxt  = lead_payload;
        rem_nxt  = REM_W'(lead_len - LEN_W'(1));
        len_nxt  = lead_len;
        cerr_nxt = 1'b0;
      end
    end else begin
      if (rem_dec == '0) begin
        res_valid = 1'b1;
        if (cerr_upd) begin
          res = '{code_point: '0, seq_length: len_r, status: ST_BAD_CONT};
        end else begin
          res = '{code_point: acc_upd, seq_length: len_r, status: ST_OK};
        end
        acc_nxt  = '0;
        rem_nxt  = '0;
        len_nxt  = '0;
        cerr_nxt = 1'b0;
      end else if (last) begin
        res_valid = 1'b1;
        res       = '{code_point: '0, seq_length: len_r, status: ST_TRUNC};
        acc_nxt   = '0;
        rem_nxt   = '0;
        len_nxt   = '0;
        cerr_nxt  = 1'b0;
      end else begin
        acc_nxt  = acc_upd;
        rem_nxt  = rem_dec;
        cerr_nxt = cerr_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      rem_r  <= '0;
      len_r  <= '0;
      cerr_r <= 1'b0;
    end else if (consume) begin
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
      len_r  <= len_nxt;
      cerr_r <= cerr_nxt;
    end
  end
endmodule

// ===== rtl/core/u8d_out_stage.sv =====
// Result register of the UTF-8 decoder: holds one result transaction.
// Depends on u8d_pkg and u8d_cp_if.
module u8d_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_load,
  input  u8d_pkg::result_t res,
  output logic             res_space,
  u8d_cp_if.source         out_chan
);
  import u8d_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign res_space = !vld_r || out_chan.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (res_load) begin
      vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid      = vld_r;
  assign out_chan.code_point = res_r.code_point;
  assign out_chan.seq_length = res_r.seq_length;
  assign out_chan.status     = res_r.status;
endmodule

// ===== dv/u8d_decode_checker.sv =====
// Result checker for the UTF-8 stream decoder: predicts each decoded result and compares it.
// Depends on u8d_pkg for widths, the status enum and the result struct.
module u8d_decode_checker
  import u8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_end_of_buffer,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CP_W-1:0]   out_code_point,
  input  logic [LEN_W-1:0]  out_seq_length,
  input  logic [1:0]        out_status,
  output int                mismatch_count,
  output int                results_owed
);

  // Decoder state as the predictor sees it.
  logic [CP_W-1:0]  accum;
  logic [REM_W-1:0] conts_left;
  logic [LEN_W-1:0] open_len;
  logic             cont_bad;

  result_t decoded_q[$];
  result_t want;
  result_t fresh;
  int      fail_cnt;

  assign mismatch_count = fail_cnt;

  function automatic void close_sequence();
    accum      = '0;
    conts_left = '0;
    open_len   = '0;
    cont_bad   = 1'b0;
  endfunction

  function automatic result_t make_result(input logic [CP_W-1:0] cp,
                                          input logic [LEN_W-1:0] len,
                                          input status_t st);
    result_t r;
    r.code_point = cp;
    r.seq_length = len;
    r.status     = st;
    return r;
  endfunction

  // Advances the predicted state by one byte; returns 1 when the byte closes a result.
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic eob,
                                     output result_t res);
    logic [LEN_W-1:0] lead_len;
    logic [CP_W-1:0]  payload;
    res = '0;
    if (conts_left == 0) begin
      if (b[7] == 1'b0) begin
        res = make_result(CP_W'(b), 3'd1, ST_OK);
        return 1'b1;
      end else if (b[7:5] == 3'b110) begin
        lead_len = 3'd2;
        payload  = CP_W'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        lead_len = 3'd3;
        payload  = CP_W'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        lead_len = 3'd4;
        payload  = CP_W'(b[2:0]);
      end else begin
        res = make_result('0, 3'd0, ST_BAD_LEAD);
        return 1'b1;
      end
      if (eob) begin
        close_sequence();
        res = make_result('0, lead_len, ST_TRUNC);
        return 1'b1;
      end
      accum      = payload;
      conts_left = REM_W'(lead_len - 3'd1);
      open_len   = lead_len;
      cont_bad   = 1'b0;
      return 1'b0;
    end

    // Once a continuation is bad, the rest of the sequence is swallowed unchecked.
    if (!cont_bad) begin
      if (b[7:6] != 2'b10) cont_bad = 1'b1;
      else accum = {accum[CP_W-7:0], b[5:0]};
    end
    conts_left = conts_left - 1'b1;

    if (conts_left == 0) begin
      res = cont_bad ? make_result('0, open_len, ST_BAD_CONT)
                     : make_result(accum, open_len, ST_OK);
      close_sequence();
      return 1'b1;
    end
    if (eob) begin
      res = make_result('0, open_len, ST_TRUNC);
      close_sequence();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      close_sequence();
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("result with none expected: code_point 0x%06h, seq_length %0d, status %0d",
                 out_code_point, out_seq_length, out_status);
          fail_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (out_code_point !== want.code_point) begin
            $error("code_point mismatch: expected 0x%06h, got 0x%06h",
                   want.code_point, out_code_point);
            fail_cnt++;
          end
          if (out_seq_length !== want.seq_length) begin
            $error("seq_length mismatch: expected %0d, got %0d",
                   want.seq_length, out_seq_length);
            fail_cnt++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            fail_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (decode_byte(in_byte, in_end_of_buffer, fresh)) decoded_q.push_back(fresh);
      end
    end
    results_owed <= decoded_q.size();
  end

endmodule

// ===== dv/utf8_stream_decoder_tb.sv =====
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus and the verdict.
// Depends on u8d_pkg, u8d_byte_if, u8d_cp_if, utf8_stream_decoder and u8d_decode_checker.
module utf8_stream_decoder_tb;
  import u8d_pkg::*;

  // The limit leaves a wide margin over the slowest correct run while still
  // catching a hung handshake.
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int PHASE_ITEMS    = 650;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 8;

  // Directed bytes, each entry {end_of_buffer, byte}. They walk through every
  // status the decoder can report and every sequence length:
  //   plain ASCII at both ends of its range, one of them closing the buffer,
  //   two, three and four byte sequences, the last one carrying all ones,
  //   a lone continuation byte and 11111xxx bytes as bad leads,
  //   a three byte sequence broken by an ASCII byte in the middle,
  //   a buffer ending right after a lead and after a first continuation,
  //   a buffer ending on a bad continuation (truncation must win),
  //   and a buffer ending exactly on the last byte of a sequence (no effect).
  localparam logic [8:0] DIRECTED [24] = '{
    {1'b0, 8'h00}, {1'b1, 8'h7F},
    {1'b0, 8'hC2}, {1'b0, 8'hA9},
    {1'b0, 8'hE2}, {1'b0, 8'h82}, {1'b0, 8'hAC},
    {1'b0, 8'hF7}, {1'b0, 8'hBF}, {1'b0, 8'hBF}, {1'b0, 8'hBF},
    {1'b0, 8'h80}, {1'b1, 8'hFF}, {1'b0, 8'hF8},
    {1'b0, 8'hE2}, {1'b0, 8'h41}, {1'b0, 8'h82},
    {1'b1, 8'hC2},
    {1'b0, 8'hF0}, {1'b1, 8'h9F},
    {1'b0, 8'hE2}, {1'b1, 8'h41},
    {1'b0, 8'hDF}, {1'b1, 8'hBF}
  };

  logic clk;
  logic rst_n;

  u8d_byte_if in_chan ();
  u8d_cp_if   out_chan ();

  // Idle rates in percent. The sender rate is only used by the stimulus process;
  // the receiver rate and the hold-off request are handed to the receiver process.
  int src_idle_pct;
  int sink_idle_pct;
  int hold_req;
  int hold_ack;
  int hold_left;
  int bytes_sent;

  int mismatches;
  int owed;

  utf8_stream_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  u8d_decode_checker decode_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_chan.valid),
    .in_ready         (in_chan.ready),
    .in_byte          (in_chan.in_byte),
    .in_end_of_buffer (in_chan.end_of_buffer),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_code_point   (out_chan.code_point),
    .out_seq_length   (out_chan.seq_length),
    .out_status       (out_chan.status),
    .mismatch_count   (mismatches),
    .results_owed     (owed)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver. Ready is redrawn every cycle from the current idle rate. When the
  // stimulus raises a hold-off request, ready stays low for a long stretch that
  // this process counts itself; the decoder's two register stages then fill up
  // and it has to push back on the byte channel.
  initial begin
    out_chan.ready <= 1'b0;
    hold_ack  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offers one byte, possibly after idle cycles, and returns at the edge
  // where the transaction completes. Valid is left high so that a following
  // byte can go out in the very next cycle without a gap.
  task automatic push_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.in_byte       <= b;
    in_chan.end_of_buffer <= eob;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stops offering bytes and waits until the checker holds no expectation. The
  // first edge lets the checker's count catch up with the last transaction.
  task automatic wait_results_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  // One random unit of traffic. Most units are well formed sequences with random
  // payload; some carry a broken continuation or end the buffer early, and the
  // rest is raw noise: a single random byte that may also end the buffer.
  task automatic send_random_unit();
    int         kind;
    int         len;
    int         bad_pos;
    int         eob_pos;
    logic [7:0] seq [4];
    kind = $urandom_range(99);
    if (kind < 15) begin
      push_byte(8'($urandom_range(255)), ($urandom_range(9) == 0));
      return;
    end
    len = $urandom_range(1, 4);
    case (len)
      1: begin
        seq[0] = {1'b0, 7'($urandom)};
      end
      2: begin
        seq[0] = {3'b110, 5'($urandom)};
      end
      3: begin
        seq[0] = {4'b1110, 4'($urandom)};
      end
      default: begin
        seq[0] = {5'b11110, 3'($urandom)};
      end
    endcase
    for (int i = 1; i < len; i++) seq[i] = {2'b10, 6'($urandom)};
    // A bad continuation is any byte whose top bits are not 10.
    if (len > 1 && $urandom_range(99) < 15) begin
      bad_pos = $urandom_range(1, len - 1);
      seq[bad_pos] = 8'($urandom_range(255));
      if (seq[bad_pos][7:6] == 2'b10) seq[bad_pos][6] = 1'b1;
    end
    // The buffer may end anywhere in the sequence; nothing of it follows the end.
    if ($urandom_range(99) < 10) eob_pos = $urandom_range(0, len - 1);
    else eob_pos = -1;
    for (int i = 0; i < len; i++) begin
      push_byte(seq[i], (i == eob_pos));
      if (i == eob_pos) break;
    end
  endtask

  // One random phase: sets both idle rates, asks the receiver for a long
  // hold-off at its start, sends about the given number of bytes and then
  // pauses until every expected result has come back.
  task automatic run_phase(input int src_pct, input int sink_pct, input int n_bytes);
    int start_count;
    start_count   = bytes_sent;
    src_idle_pct  = src_pct;
    sink_idle_pct <= sink_pct;
    hold_req      <= hold_req + 1;
    while (bytes_sent - start_count < n_bytes) send_random_unit();
    wait_results_drained();
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.in_byte       <= '0;
    in_chan.end_of_buffer <= 1'b0;
    sink_idle_pct         <= 0;
    hold_req              <= 0;
    src_idle_pct = 0;
    bytes_sent   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bytes run under the first phase's idle rates.
    src_idle_pct  = 25;
    sink_idle_pct <= 64;
    foreach (DIRECTED[i]) push_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_results_drained();

    // Sender idles lightly and the receiver heavily, then the other way round,
    // then both run flat out.
    run_phase(25, 64, PHASE_ITEMS);
    run_phase(64, 25, PHASE_ITEMS);
    run_phase(0, 0, PHASE_ITEMS);

    // A settle wait catches any stray result before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/u8d_pkg.sv
rtl/core/u8d_byte_if.sv
rtl/core/u8d_cp_if.sv
rtl/core/u8d_in_stage.sv
rtl/core/u8d_step.sv
rtl/core/u8d_out_stage.sv
rtl/core/utf8_stream_decoder.sv
dv/u8d_decode_checker.sv
dv/utf8_stream_decoder_tb.sv
